// ===== rtl/command_line_tokenizer_top_macros.svh =====
// Assertion macros shared by the command line tokenizer RTL.
// Depends on nothing; included by the controller and the datapath.
`ifndef COMMAND_LINE_TOKENIZER_TOP_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLT_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CLT_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cltok_pkg.sv =====
// Package for the command line tokenizer: codes, types, byte constants and
// the controller/datapath command and status structs. Depends on nothing.
package cltok_pkg;

    localparam int PENDING_DEPTH_DEF = 16;
    localparam int MAX_ARGS_DEF      = 15;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_EOL  = 1'b1;

    typedef enum logic [2:0] {
        MODE_LEAD,
        MODE_CMD,
        MODE_GAP,
        MODE_MID,
        MODE_TRAIL
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_LAST,
        ST_EOL
    } state_t;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_END_TOKEN,
        KIND_END_LINE
    } kind_t;

    typedef enum logic [1:0] {
        TOK_CMD,
        TOK_MID,
        TOK_TRAIL
    } tok_t;

    typedef enum logic [2:0] {
        SEL_ZERO,
        SEL_UPCASE,
        SEL_RAW,
        SEL_PEND,
        SEL_HOLD
    } bsel_t;

    typedef struct packed {
        logic  hold_load;
        logic  emit;
        kind_t kind;
        tok_t  tok;
        bsel_t byte_sel;
        logic  use_argn;
        logic  ok;
        logic  last;
        logic  mode_we;
        mode_t next_mode;
        logic  pend_push;
        logic  pend_clear;
        logic  arg_finish;
        logic  line_reset;
        logic  flush_start;
        logic  flush_step;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  out_free;
        logic  blank;
        logic  colon;
        logic  pend_empty;
        logic  flush_end;
    } status_t;

    function automatic logic [7:0] upcase(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= CH_LOW_A && b <= CH_LOW_Z)
        begin
            r = b - CASE_GAP;
        end
        return r;
    endfunction

endpackage

// ===== rtl/cltok_ctrl.sv =====
// Controller of the command line tokenizer: sequencer state machine that
// decides every record. Depends on cltok_pkg and the assertion macro header.
`include "command_line_tokenizer_top_macros.svh"

module cltok_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  logic              opcode,
    input  cltok_pkg::status_t sts,
    output cltok_pkg::cmd_t    cmd
);

    cltok_pkg::state_t state_reg;
    cltok_pkg::state_t state_next;
    logic              fire;
    logic              trail_like;
    logic              tok_open;

    assign byte_ready = (state_reg == cltok_pkg::ST_IDLE) && sts.out_free;
    assign fire       = byte_valid && byte_ready;

    // Unused mode codes behave as the trailing argument.
    assign trail_like = !(sts.mode == cltok_pkg::MODE_LEAD || sts.mode == cltok_pkg::MODE_CMD
                       || sts.mode == cltok_pkg::MODE_GAP || sts.mode == cltok_pkg::MODE_MID);
    assign tok_open   = trail_like || sts.mode == cltok_pkg::MODE_CMD
                       || sts.mode == cltok_pkg::MODE_MID;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cltok_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cltok_pkg::ST_IDLE:
            begin
                if (fire)
                begin
                    if (opcode == cltok_pkg::OP_EOL)
                    begin
                        if (tok_open)
                        begin
                            state_next = cltok_pkg::ST_EOL;
                        end
                    end
                    else if (trail_like && !sts.blank && !sts.pend_empty)
                    begin
                        state_next = cltok_pkg::ST_FLUSH;
                    end
                end
            end
            cltok_pkg::ST_FLUSH:
            begin
                if (sts.out_free && sts.flush_end)
                begin
                    state_next = cltok_pkg::ST_LAST;
                end
            end
            cltok_pkg::ST_LAST, cltok_pkg::ST_EOL:
            begin
                if (sts.out_free)
                begin
                    state_next = cltok_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cltok_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.kind      = cltok_pkg::KIND_BYTE;
        cmd.tok       = cltok_pkg::TOK_CMD;
        cmd.byte_sel  = cltok_pkg::SEL_ZERO;
        cmd.next_mode = cltok_pkg::MODE_LEAD;
        unique case (state_reg)
            cltok_pkg::ST_IDLE:
            begin
                if (fire)
                begin
                    cmd.hold_load = 1'b1;
                    if (opcode == cltok_pkg::OP_EOL)
                    begin
                        unique case (sts.mode) inside
                            cltok_pkg::MODE_LEAD, cltok_pkg::MODE_GAP:
                            begin
                                cmd.emit       = 1'b1;
                                cmd.kind       = cltok_pkg::KIND_END_LINE;
                                cmd.ok         = (sts.mode == cltok_pkg::MODE_GAP);
                                cmd.last       = 1'b1;
                                cmd.line_reset = 1'b1;
                            end
                            cltok_pkg::MODE_CMD:
                            begin
                                cmd.emit = 1'b1;
                                cmd.kind = cltok_pkg::KIND_END_TOKEN;
                            end
                            cltok_pkg::MODE_MID:
                            begin
                                cmd.emit     = 1'b1;
                                cmd.kind     = cltok_pkg::KIND_END_TOKEN;
                                cmd.tok      = cltok_pkg::TOK_MID;
                                cmd.use_argn = 1'b1;
                            end
                            default:
                            begin
                                cmd.emit     = 1'b1;
                                cmd.kind     = cltok_pkg::KIND_END_TOKEN;
                                cmd.tok      = cltok_pkg::TOK_TRAIL;
                                cmd.use_argn = 1'b1;
                            end
                        endcase
                    end
                    else
                    begin
                        unique case (sts.mode)
                            cltok_pkg::MODE_LEAD:
                            begin
                                if (!sts.blank)
                                begin
                                    cmd.emit      = 1'b1;
                                    cmd.byte_sel  = cltok_pkg::SEL_UPCASE;
                                    cmd.last      = 1'b1;
                                    cmd.mode_we   = 1'b1;
                                    cmd.next_mode = cltok_pkg::MODE_CMD;
                                end
                            end
                            cltok_pkg::MODE_CMD:
                            begin
                                cmd.emit = 1'b1;
                                cmd.last = 1'b1;
                                if (sts.blank)
                                begin
                                    cmd.kind      = cltok_pkg::KIND_END_TOKEN;
                                    cmd.mode_we   = 1'b1;
                                    cmd.next_mode = cltok_pkg::MODE_GAP;
                                end
                                else
                                begin
                                    cmd.byte_sel = cltok_pkg::SEL_UPCASE;
                                end
                            end
                            cltok_pkg::MODE_GAP:
                            begin
                                if (!sts.blank)
                                begin
                                    cmd.mode_we = 1'b1;
                                    if (sts.colon)
                                    begin
                                        cmd.next_mode  = cltok_pkg::MODE_TRAIL;
                                        cmd.pend_clear = 1'b1;
                                    end
                                    else
                                    begin
                                        cmd.next_mode = cltok_pkg::MODE_MID;
                                        cmd.emit      = 1'b1;
                                        cmd.tok       = cltok_pkg::TOK_MID;
                                        cmd.byte_sel  = cltok_pkg::SEL_RAW;
                                        cmd.use_argn  = 1'b1;
                                        cmd.last      = 1'b1;
                                    end
                                end
                            end
                            cltok_pkg::MODE_MID:
                            begin
                                cmd.emit     = 1'b1;
                                cmd.tok      = cltok_pkg::TOK_MID;
                                cmd.use_argn = 1'b1;
                                cmd.last     = 1'b1;
                                if (sts.blank)
                                begin
                                    cmd.kind       = cltok_pkg::KIND_END_TOKEN;
                                    cmd.arg_finish = 1'b1;
                                    cmd.mode_we    = 1'b1;
                                    cmd.next_mode  = cltok_pkg::MODE_GAP;
                                end
                                else
                                begin
                                    cmd.byte_sel = cltok_pkg::SEL_RAW;
                                end
                            end
                            default:
                            begin
                                cmd.mode_we   = 1'b1;
                                cmd.next_mode = cltok_pkg::MODE_TRAIL;
                                if (sts.blank)
                                begin
                                    cmd.pend_push = 1'b1;
                                end
                                else if (sts.pend_empty)
                                begin
                                    cmd.emit     = 1'b1;
                                    cmd.tok      = cltok_pkg::TOK_TRAIL;
                                    cmd.byte_sel = cltok_pkg::SEL_RAW;
                                    cmd.use_argn = 1'b1;
                                    cmd.last     = 1'b1;
                                end
                                else
                                begin
                                    cmd.flush_start = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
            cltok_pkg::ST_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.tok        = cltok_pkg::TOK_TRAIL;
                    cmd.byte_sel   = cltok_pkg::SEL_PEND;
                    cmd.use_argn   = 1'b1;
                    cmd.flush_step = 1'b1;
                end
            end
            cltok_pkg::ST_LAST:
            begin
                if (sts.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.tok        = cltok_pkg::TOK_TRAIL;
                    cmd.byte_sel   = cltok_pkg::SEL_HOLD;
                    cmd.use_argn   = 1'b1;
                    cmd.last       = 1'b1;
                    cmd.pend_clear = 1'b1;
                end
            end
            cltok_pkg::ST_EOL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.kind       = cltok_pkg::KIND_END_LINE;
                    cmd.ok         = 1'b1;
                    cmd.last       = 1'b1;
                    cmd.line_reset = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // A flush only runs inside a trailing argument with whitespace held.
    `CLT_ASSERT_NOW(a_flush_needs_pending, clk, rst_n, state_reg == cltok_pkg::ST_FLUSH, sts.mode == cltok_pkg::MODE_TRAIL && !sts.pend_empty, "flush without pending whitespace")

endmodule

// ===== rtl/cltok_dpath.sv =====
// Datapath of the command line tokenizer: parse mode, pending whitespace
// memory, counters and the output record register. Depends on cltok_pkg.
`include "command_line_tokenizer_top_macros.svh"

module cltok_dpath #(
    parameter int PENDING_DEPTH = cltok_pkg::PENDING_DEPTH_DEF,
    parameter int MAX_ARGS      = cltok_pkg::MAX_ARGS_DEF,
    localparam int ARG_W        = $clog2(MAX_ARGS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         data_byte,
    input  cltok_pkg::cmd_t    cmd,
    output cltok_pkg::status_t sts,
    output logic               rec_valid,
    input  logic               rec_ready,
    output logic [1:0]         record_kind,
    output logic [1:0]         token_type,
    output logic [7:0]         token_byte,
    output logic [ARG_W-1:0]   arg_number,
    output logic               line_ok,
    output logic               overflow_flag,
    output logic               last_of_run
);

    localparam int PIDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CNT_W  = $clog2(PENDING_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(PENDING_DEPTH);
    localparam logic [ARG_W-1:0] ARG_MAX_C = ARG_W'(MAX_ARGS);

    cltok_pkg::mode_t  mode_reg;
    cltok_pkg::mode_t  mode_next;
    logic [CNT_W-1:0]  pend_cnt_reg;
    logic [CNT_W-1:0]  pend_cnt_next;
    logic [ARG_W-1:0]  arg_cnt_reg;
    logic [ARG_W-1:0]  arg_cnt_next;
    logic              sticky_reg;
    logic              sticky_next;
    logic [PIDX_W-1:0] flush_idx_reg;
    logic [PIDX_W-1:0] flush_idx_next;
    logic              rec_valid_reg;
    logic              rec_valid_next;

    logic              pend_mem [PENDING_DEPTH];
    logic              rd_bit_reg;
    logic [7:0]        hold_reg;

    logic [1:0]        kind_reg;
    logic [1:0]        tok_reg;
    logic [7:0]        byte_reg;
    logic [ARG_W-1:0]  argn_reg;
    logic              ok_reg;
    logic              ovf_reg;
    logic              last_reg;

    logic              pend_full;
    logic              arg_at_max;
    logic              flush_end;
    logic [7:0]        byte_mux;

    assign pend_full  = (pend_cnt_reg == DEPTH_C);
    assign arg_at_max = (arg_cnt_reg == ARG_MAX_C);
    assign flush_end  = ((CNT_W'(flush_idx_reg) + CNT_W'(1)) == pend_cnt_reg);

    assign sts.mode       = mode_reg;
    assign sts.out_free   = !rec_valid_reg || rec_ready;
    assign sts.blank      = (data_byte == cltok_pkg::CH_SPACE) || (data_byte == cltok_pkg::CH_TAB);
    assign sts.colon      = (data_byte == cltok_pkg::CH_COLON);
    assign sts.pend_empty = (pend_cnt_reg == '0);
    assign sts.flush_end  = flush_end;

    always_comb
    begin
        mode_next = mode_reg;
        if (cmd.line_reset)
        begin
            mode_next = cltok_pkg::MODE_LEAD;
        end
        else if (cmd.mode_we)
        begin
            mode_next = cmd.next_mode;
        end

        pend_cnt_next = pend_cnt_reg;
        if (cmd.line_reset || cmd.pend_clear)
        begin
            pend_cnt_next = '0;
        end
        else if (cmd.pend_push && !pend_full)
        begin
            pend_cnt_next = pend_cnt_reg + CNT_W'(1);
        end

        arg_cnt_next = arg_cnt_reg;
        if (cmd.line_reset)
        begin
            arg_cnt_next = '0;
        end
        else if (cmd.arg_finish && !arg_at_max)
        begin
            arg_cnt_next = arg_cnt_reg + ARG_W'(1);
        end

        sticky_next = sticky_reg;
        if (cmd.line_reset)
        begin
            sticky_next = 1'b0;
        end
        else if ((cmd.pend_push && pend_full) || (cmd.arg_finish && arg_at_max))
        begin
            sticky_next = 1'b1;
        end

        flush_idx_next = flush_idx_reg;
        if (cmd.flush_start)
        begin
            flush_idx_next = '0;
        end
        else if (cmd.flush_step && !flush_end)
        begin
            flush_idx_next = flush_idx_reg + PIDX_W'(1);
        end

        rec_valid_next = rec_valid_reg;
        if (cmd.emit)
        begin
            rec_valid_next = 1'b1;
        end
        else if (rec_ready)
        begin
            rec_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        case (cmd.byte_sel)
            cltok_pkg::SEL_UPCASE: byte_mux = cltok_pkg::upcase(data_byte);
            cltok_pkg::SEL_RAW:    byte_mux = data_byte;
            cltok_pkg::SEL_PEND:   byte_mux = rd_bit_reg ? cltok_pkg::CH_TAB : cltok_pkg::CH_SPACE;
            cltok_pkg::SEL_HOLD:   byte_mux = hold_reg;
            default:               byte_mux = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= cltok_pkg::MODE_LEAD;
            pend_cnt_reg  <= '0;
            arg_cnt_reg   <= '0;
            sticky_reg    <= 1'b0;
            flush_idx_reg <= '0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            pend_cnt_reg  <= pend_cnt_next;
            arg_cnt_reg   <= arg_cnt_next;
            sticky_reg    <= sticky_next;
            flush_idx_reg <= flush_idx_next;
            rec_valid_reg <= rec_valid_next;
        end
    end

    // Pending whitespace memory: one write port, one registered read port.
    // The read always tracks the next flush index, so the entry to emit is
    // ready in rd_bit_reg on the cycle the flush reaches it.
    always_ff @(posedge clk)
    begin
        if (cmd.pend_push && !pend_full)
        begin
            pend_mem[pend_cnt_reg[PIDX_W-1:0]] <= (data_byte == cltok_pkg::CH_TAB);
        end
        rd_bit_reg <= pend_mem[flush_idx_next];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hold_load)
        begin
            hold_reg <= data_byte;
        end
        if (cmd.emit)
        begin
            kind_reg <= cmd.kind;
            tok_reg  <= cmd.tok;
            byte_reg <= byte_mux;
            argn_reg <= cmd.use_argn ? arg_cnt_reg : '0;
            ok_reg   <= cmd.ok;
            ovf_reg  <= sticky_reg;
            last_reg <= cmd.last;
        end
    end

    assign rec_valid     = rec_valid_reg;
    assign record_kind   = kind_reg;
    assign token_type    = tok_reg;
    assign token_byte    = byte_reg;
    assign arg_number    = argn_reg;
    assign line_ok       = ok_reg;
    assign overflow_flag = ovf_reg;
    assign last_of_run   = last_reg;

    `CLT_ASSERT_NOW(a_pend_only_trail, clk, rst_n, pend_cnt_reg != '0, mode_reg == cltok_pkg::MODE_TRAIL, "pending whitespace outside trailing argument")
    `CLT_ASSERT_NXT(a_line_reset_clears, clk, rst_n, cmd.line_reset, mode_reg == cltok_pkg::MODE_LEAD && pend_cnt_reg == '0 && arg_cnt_reg == '0 && !sticky_reg, "line state not cleared")
    `CLT_ASSERT_NOW(a_sticky_cause, clk, rst_n, $rose(sticky_reg), $past((cmd.pend_push && pend_full) || (cmd.arg_finish && arg_at_max)), "overflow flag set without saturation")

endmodule

// ===== rtl/command_line_tokenizer_top.sv =====
// Top level of the command line tokenizer: joins the sequencer controller
// and the datapath. Depends on cltok_pkg, cltok_ctrl and cltok_dpath.
//
//   Channel   Handshake                Beat contents
//   -------   ---------------------    ------------------------------------------
//   byte      byte_valid, byte_ready   opcode, data_byte
//   record    rec_valid,  rec_ready    record_kind, token_type, token_byte,
//                                      arg_number, line_ok, overflow_flag,
//                                      last_of_run
//
// An ordinary byte beat gives at most one record.
// A trailing-argument byte after N held whitespace bytes is taken in ST_IDLE,
// which also fetches the first held entry; ST_FLUSH then sends the N held entries
// through the single read port of the pending whitespace memory, and ST_LAST sends
// the byte itself. An end of line with a token open gives two records (end of
// token, end of line). The record register parts the channels; a record stall
// holds the byte channel. Reset is asynchronous; no clearing pass is needed.

module command_line_tokenizer_top #(
    parameter int PENDING_DEPTH = cltok_pkg::PENDING_DEPTH_DEF,
    parameter int MAX_ARGS      = cltok_pkg::MAX_ARGS_DEF,
    localparam int ARG_W        = $clog2(MAX_ARGS + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    output logic             byte_ready,
    input  logic             opcode,
    input  logic [7:0]       data_byte,
    output logic             rec_valid,
    input  logic             rec_ready,
    output logic [1:0]       record_kind,
    output logic [1:0]       token_type,
    output logic [7:0]       token_byte,
    output logic [ARG_W-1:0] arg_number,
    output logic             line_ok,
    output logic             overflow_flag,
    output logic             last_of_run
);

    // Command and status between the sequencer and the datapath.
    cltok_pkg::cmd_t    cmd;
    cltok_pkg::status_t sts;

    // The controller owns every decision: which record goes out, how the
    // parse mode moves, and when the pending whitespace is flushed.
    cltok_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .opcode     (opcode),
        .sts        (sts),
        .cmd        (cmd)
    );

    // The datapath holds the line state, the pending whitespace memory and
    // the record register that drives the record channel.
    cltok_dpath #(
        .PENDING_DEPTH (PENDING_DEPTH),
        .MAX_ARGS      (MAX_ARGS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (data_byte),
        .cmd           (cmd),
        .sts           (sts),
        .rec_valid     (rec_valid),
        .rec_ready     (rec_ready),
        .record_kind   (record_kind),
        .token_type    (token_type),
        .token_byte    (token_byte),
        .arg_number    (arg_number),
        .line_ok       (line_ok),
        .overflow_flag (overflow_flag),
        .last_of_run   (last_of_run)
    );

endmodule
